@@ hdl/npcb_pkg.sv @@
// Package for the custom-alphabet number parser.
// Holds the transaction types, the classified token, register indexes and character constants.
// Depends on nothing; every other file takes from it by scoped names.
package npcb_pkg;

  localparam int unsigned AlphaSlots = 32;
  localparam int unsigned MaxRadix   = 32;

  localparam logic [2:0] RegDigitsLow    = 3'd0;
  localparam logic [2:0] RegDigitsSecond = 3'd1;
  localparam logic [2:0] RegDigitsThird  = 3'd2;
  localparam logic [2:0] RegDigitsHigh   = 3'd3;
  localparam logic [2:0] RegRadixLength  = 3'd4;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharCr    = 8'h0D;

  typedef logic [AlphaSlots-1:0][7:0] alphabet_t;

  typedef enum logic [1:0] {
    PhSkipWs = 2'd0,
    PhSigns  = 2'd1,
    PhDigits = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] parsed_value;
    logic               overflowed;
    logic               alphabet_ok;
  } out_item_t;

  typedef struct packed {
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       digit_ok;
    logic [4:0] digit;
    logic [5:0] radix;
    logic       alpha_ok;
    logic       last;
  } token_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharNl) ||
           (c == CharVt) || (c == CharFf) || (c == CharCr);
  endfunction

endpackage

@@ hdl/npcb_front.sv @@
// Front end of the number parser: classifies each incoming character.
// Looks the character up in the alphabet and checks the alphabet for validity.
// Depends on npcb_pkg.
module npcb_front (
  input  npcb_pkg::in_item_t  item_i,
  input  npcb_pkg::alphabet_t alphabet_i,
  input  logic [5:0]          radix_i,
  output npcb_pkg::token_t    token_o
);

  logic       hit;
  logic [4:0] idx;
  logic       bad;
  logic       ok;

  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = npcb_pkg::AlphaSlots - 1; i >= 0; i--) begin
      if ((6'(i) < radix_i) && (alphabet_i[i] == item_i.character)) begin
        hit = 1'b1;
        idx = 5'(i);
      end
    end
  end

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < npcb_pkg::AlphaSlots; i++) begin
      if (6'(i) < radix_i) begin
        if ((alphabet_i[i] == npcb_pkg::CharNul) || (alphabet_i[i] == npcb_pkg::CharPlus) ||
            (alphabet_i[i] == npcb_pkg::CharMinus) || npcb_pkg::is_ws(alphabet_i[i])) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < npcb_pkg::AlphaSlots; j++) begin
          if ((6'(j) < radix_i) && (alphabet_i[j] == alphabet_i[i])) begin
            bad = 1'b1;
          end
        end
      end
    end
    ok = (radix_i >= 6'd2) && (radix_i <= 6'(npcb_pkg::MaxRadix)) && !bad;
  end

  always_comb begin
    token_o.is_ws    = npcb_pkg::is_ws(item_i.character);
    token_o.is_plus  = (item_i.character == npcb_pkg::CharPlus);
    token_o.is_minus = (item_i.character == npcb_pkg::CharMinus);
    token_o.digit_ok = hit && (item_i.character != npcb_pkg::CharNul);
    token_o.digit    = idx;
    token_o.radix    = radix_i;
    token_o.alpha_ok = ok;
    token_o.last     = item_i.last_char;
  end

endmodule

@@ hdl/npcb_fifo.sv @@
// Short token queue between the front end and the back end of the parser.
// A register ring with read and write pointers and a fill count.
// Depends on npcb_pkg.
module npcb_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  npcb_pkg::token_t       push_data_i,
  input  logic                   pop_i,
  output npcb_pkg::token_t       pop_data_o,
  output npcb_pkg::fifo_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  npcb_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(Depth));
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/npcb_back.sv @@
// Back end of the number parser: phase machine, sign and multiply-add accumulator.
// Emits the result of a string through an output register on its last character.
// Depends on npcb_pkg.
module npcb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_valid_i,
  input  npcb_pkg::token_t    tok_i,
  output logic                tok_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output npcb_pkg::out_item_t out_data_o
);

  npcb_pkg::phase_e phase_q, phase_d, ph;
  logic             neg_q, neg_d, neg_n;
  logic [31:0]      acc_q, acc_d, acc_n;
  logic             ovf_q, ovf_d, ovf_n;
  logic [37:0]      prod;
  logic [38:0]      sum;
  logic             take;
  logic             out_free;
  logic             out_valid_q, out_valid_d, res_load;
  logic [31:0]      res_acc_q;
  logic             res_neg_q, res_ovf_q, res_ok_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign tok_ready_o = !tok_i.last || out_free;
  assign take        = tok_valid_i && tok_ready_o;
  assign res_load    = take && tok_i.last;

  always_comb begin
    ph    = phase_q;
    neg_n = neg_q;
    acc_n = acc_q;
    ovf_n = ovf_q;
    prod  = 38'(acc_q) * 38'(tok_i.radix);
    sum   = 39'(prod) + 39'(tok_i.digit);
    if ((ph == npcb_pkg::PhSkipWs) && !tok_i.is_ws) begin
      ph = npcb_pkg::PhSigns;
    end
    if (ph == npcb_pkg::PhSigns) begin
      if (tok_i.is_minus) begin
        neg_n = !neg_q;
      end else if (!tok_i.is_plus) begin
        ph = npcb_pkg::PhDigits;
      end
    end
    if (ph == npcb_pkg::PhDigits) begin
      if (!tok_i.digit_ok) begin
        ph = npcb_pkg::PhDone;
      end else begin
        acc_n = sum[31:0];
        ovf_n = ovf_q || (sum[38:32] != '0);
      end
    end

    phase_d     = phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      if (tok_i.last) begin
        phase_d     = npcb_pkg::PhSkipWs;
        neg_d       = 1'b0;
        acc_d       = '0;
        ovf_d       = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        phase_d = ph;
        neg_d   = neg_n;
        acc_d   = acc_n;
        ovf_d   = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= npcb_pkg::PhSkipWs;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_ok_q  <= tok_i.alpha_ok;
      res_acc_q <= tok_i.alpha_ok ? acc_n : 32'd0;
      res_neg_q <= tok_i.alpha_ok && neg_n;
      res_ovf_q <= tok_i.alpha_ok && ovf_n;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.parsed_value = res_neg_q ? -$signed(res_acc_q) : $signed(res_acc_q);
  assign out_data_o.overflowed   = res_ovf_q;
  assign out_data_o.alphabet_ok  = res_ok_q;

endmodule

@@ hdl/number_parse_custom_base_top.sv @@
// Top level of the custom-alphabet number parser.
// Holds the configuration registers and joins front end, token queue and back end.
// Depends on npcb_pkg, npcb_front, npcb_fifo and npcb_back.

// The parser takes one character per clock while its token queue has room and returns one
// transaction per string, carrying the signed 32-bit value, an overflow flag and an alphabet
// check flag, when the character marked last has been taken. Each character is classified in
// the cycle it arrives and queued; the back end then applies one 32-by-6 multiply-add per
// cycle, which sets the sustained rate of one character per clock, and stalls a last
// character until the output register is free to take its result. Configuration writes
// take effect at once and are meant to happen only while no string is in flight.
module number_parse_custom_base_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  npcb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output npcb_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);

  logic [3:0][63:0]       digits_q;
  logic [5:0]             radix_q;
  npcb_pkg::alphabet_t    alphabet;
  npcb_pkg::token_t       in_tok, head_tok;
  npcb_pkg::fifo_status_t q_stat;
  logic                   back_ready;
  logic                   q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      radix_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        npcb_pkg::RegDigitsLow:    digits_q[0] <= cfg_data_i;
        npcb_pkg::RegDigitsSecond: digits_q[1] <= cfg_data_i;
        npcb_pkg::RegDigitsThird:  digits_q[2] <= cfg_data_i;
        npcb_pkg::RegDigitsHigh:   digits_q[3] <= cfg_data_i;
        npcb_pkg::RegRadixLength:  radix_q     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign alphabet   = digits_q;
  assign in_ready_o = !q_stat.full;
  assign q_pop      = back_ready && !q_stat.empty;

  npcb_front u_front (
    .item_i     (in_data_i),
    .alphabet_i (alphabet),
    .radix_i    (radix_q),
    .token_o    (in_tok)
  );

  npcb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (in_tok),
    .pop_i       (q_pop),
    .pop_data_o  (head_tok),
    .status_o    (q_stat)
  );

  npcb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!q_stat.empty),
    .tok_i       (head_tok),
    .tok_ready_o (back_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.empty && q_stat.full))
    else $error("token queue reports empty and full together");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && head_tok.last) |=> out_valid_o)
    else $error("last character popped without a result");

  a_bad_alpha_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.alphabet_ok) |->
      (out_data_o.parsed_value == 32'sd0) && !out_data_o.overflowed)
    else $error("invalid alphabet result is not zero");
`endif

endmodule

@@ tb/sv/npcb_tb_pkg.sv @@
// Scoreboard for the custom-alphabet number parser testbench.
// Tracks the parser state and register copies, predicts each result and checks it.
// Depends on npcb_pkg for the transaction types, phases, register indexes and characters.
package npcb_tb_pkg;

  function automatic bit is_blank(logic [7:0] c);
    return (c == npcb_pkg::CharSpace) || (c == npcb_pkg::CharTab) ||
           (c == npcb_pkg::CharNl) || (c == npcb_pkg::CharVt) ||
           (c == npcb_pkg::CharFf) || (c == npcb_pkg::CharCr);
  endfunction

  class parse_board;
    logic [63:0]           bank [4];
    logic [5:0]            radix;
    npcb_pkg::phase_e      phase;
    bit                    negative;
    logic [31:0]           accum;
    bit                    overflow_seen;
    npcb_pkg::out_item_t   expected_values [$];
    int unsigned           errors;
    int unsigned           results_seen;
    int unsigned           overflow_count;
    int unsigned           invalid_count;

    function new();
      foreach (bank[i]) bank[i] = '0;
      radix = '0;
      errors = 0;
      results_seen = 0;
      overflow_count = 0;
      invalid_count = 0;
      clear_string();
    endfunction

    function void clear_string();
      phase = npcb_pkg::PhSkipWs;
      negative = 1'b0;
      accum = '0;
      overflow_seen = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        npcb_pkg::RegDigitsLow:    bank[0] = data;
        npcb_pkg::RegDigitsSecond: bank[1] = data;
        npcb_pkg::RegDigitsThird:  bank[2] = data;
        npcb_pkg::RegDigitsHigh:   bank[3] = data;
        npcb_pkg::RegRadixLength:  radix = data[5:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] alpha_char(int pos);
      return bank[pos / 8][(pos % 8) * 8 +: 8];
    endfunction

    function bit alphabet_valid();
      int         len;
      logic [7:0] c;
      len = radix;
      if (len < 2 || len > npcb_pkg::MaxRadix) return 1'b0;
      for (int i = 0; i < len; i++) begin
        c = alpha_char(i);
        if (c == npcb_pkg::CharNul || c == npcb_pkg::CharPlus ||
            c == npcb_pkg::CharMinus || is_blank(c)) return 1'b0;
        for (int j = i + 1; j < len; j++) begin
          if (alpha_char(j) == c) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function int digit_value(logic [7:0] c);
      int len;
      len = (radix > 32) ? 32 : radix;
      for (int i = 0; i < len; i++) begin
        if (alpha_char(i) == c) return i;
      end
      return -1;
    endfunction

    function void take_char(npcb_pkg::in_item_t it);
      logic [7:0]          c;
      bit                  ok;
      int                  d;
      logic [63:0]         sum;
      npcb_pkg::out_item_t want;
      c = it.character;
      ok = alphabet_valid();
      if (phase == npcb_pkg::PhSkipWs && !is_blank(c)) phase = npcb_pkg::PhSigns;
      if (phase == npcb_pkg::PhSigns) begin
        if (c == npcb_pkg::CharMinus) negative = !negative;
        else if (c != npcb_pkg::CharPlus) phase = npcb_pkg::PhDigits;
      end
      if (phase == npcb_pkg::PhDigits) begin
        d = (c != npcb_pkg::CharNul) ? digit_value(c) : -1;
        if (d < 0) begin
          phase = npcb_pkg::PhDone;
        end else begin
          sum = 64'(accum) * 64'(radix) + 64'(d);
          if (sum[63:32] != '0) overflow_seen = 1'b1;
          accum = sum[31:0];
        end
      end
      if (!it.last_char) return;
      if (ok) begin
        want.parsed_value = negative ? (32'd0 - accum) : accum;
        want.overflowed = overflow_seen;
        want.alphabet_ok = 1'b1;
      end else begin
        want = '0;
      end
      expected_values.push_back(want);
      clear_string();
    endfunction

    function void check_value(npcb_pkg::out_item_t got);
      npcb_pkg::out_item_t want;
      if (expected_values.size() == 0) begin
        $display("%0t: result transaction with nothing expected: expected none actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_values.pop_front();
      results_seen++;
      overflow_count += want.overflowed;
      invalid_count += !want.alphabet_ok;
      if (got.parsed_value !== want.parsed_value) begin
        $display("%0t: parsed_value mismatch: expected %0d actual %0d",
                 $time, want.parsed_value, got.parsed_value);
        errors++;
      end
      if (got.overflowed !== want.overflowed) begin
        $display("%0t: overflowed mismatch: expected %b actual %b",
                 $time, want.overflowed, got.overflowed);
        errors++;
      end
      if (got.alphabet_ok !== want.alphabet_ok) begin
        $display("%0t: alphabet_ok mismatch: expected %b actual %b",
                 $time, want.alphabet_ok, got.alphabet_ok);
        errors++;
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
// Top of the custom-alphabet number parser testbench: clock, reset, drivers and watchdog.
// Depends on npcb_pkg, npcb_tb_pkg and number_parse_custom_base_top.
module tb_top;

  localparam int PhaseItems = 100;
  localparam int HoldCycles = 400;
  localparam int QuietLimit = 5000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  npcb_pkg::in_item_t   in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  npcb_pkg::out_item_t  out_data_o;
  logic                 cfg_we_i;
  logic [2:0]           cfg_idx_i;
  logic [63:0]          cfg_data_i;

  npcb_tb_pkg::parse_board board = new();
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  int          items_sent = 0;
  int          phases = 0;
  logic [7:0]  alpha [32];
  int          cur_radix = 0;
  logic [7:0]  blanks [6] = '{npcb_pkg::CharSpace, npcb_pkg::CharTab, npcb_pkg::CharNl,
                              npcb_pkg::CharVt, npcb_pkg::CharFf, npcb_pkg::CharCr};
  logic [7:0]  illegal [9] = '{npcb_pkg::CharNul, npcb_pkg::CharPlus, npcb_pkg::CharMinus,
                               npcb_pkg::CharSpace, npcb_pkg::CharTab, npcb_pkg::CharNl,
                               npcb_pkg::CharVt, npcb_pkg::CharFf, npcb_pkg::CharCr};

  number_parse_custom_base_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit legal_digit(logic [7:0] c);
    return c != npcb_pkg::CharNul && c != npcb_pkg::CharPlus &&
           c != npcb_pkg::CharMinus && !npcb_tb_pkg::is_blank(c);
  endfunction

  task automatic random_alphabet();
    logic [7:0] c;
    bit         clash;
    for (int i = 0; i < 32; i++) begin
      do begin
        c = 8'($urandom_range(255));
        clash = !legal_digit(c);
        for (int k = 0; k < i; k++) if (alpha[k] == c) clash = 1'b1;
      end while (clash);
      alpha[i] = c;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic load_alphabet();
    logic [2:0]  idx_list [4];
    logic [63:0] word;
    idx_list = '{npcb_pkg::RegDigitsLow, npcb_pkg::RegDigitsSecond,
                 npcb_pkg::RegDigitsThird, npcb_pkg::RegDigitsHigh};
    for (int w = 0; w < 4; w++) begin
      for (int k = 0; k < 8; k++) word[k*8 +: 8] = alpha[w*8 + k];
      write_reg(idx_list[w], word);
    end
    word = {$urandom, $urandom};
    word[5:0] = 6'(cur_radix);
    write_reg(npcb_pkg::RegRadixLength, word);
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    npcb_pkg::in_item_t it;
    it.character = c;
    it.last_char = last;
    while (!steady && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_char(it);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] chars [$]);
    for (int i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic send_text(input string t);
    logic [7:0] chars [$];
    for (int i = 0; i < t.len(); i++) chars.push_back(t[i]);
    send_bytes(chars);
  endtask

  task automatic send_random_string();
    logic [7:0] chars [$];
    int         eff;
    int         n;
    eff = (cur_radix > 32) ? 32 : cur_radix;
    if ($urandom_range(99) < 80 && eff > 0) begin
      repeat ($urandom_range(3)) chars.push_back(blanks[$urandom_range(5)]);
      repeat ($urandom_range(3)) begin
        chars.push_back($urandom_range(1) ? npcb_pkg::CharMinus : npcb_pkg::CharPlus);
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
      repeat (n) chars.push_back(alpha[$urandom_range(eff - 1)]);
      if ($urandom_range(1)) begin
        chars.push_back(($urandom_range(3) == 0) ? npcb_pkg::CharNul :
                        8'($urandom_range(255)));
        repeat ($urandom_range(4)) chars.push_back(8'($urandom_range(255)));
      end
    end else begin
      repeat ($urandom_range(10, 1)) chars.push_back(8'($urandom_range(255)));
    end
    send_bytes(chars);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input bit pause_mid);
    int start;
    bit paused;
    start = items_sent;
    paused = 1'b0;
    while (items_sent - start < PhaseItems) begin
      send_random_string();
      if (pause_mid && !paused && items_sent - start >= PhaseItems / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int         quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) board.check_value(out_data_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  initial begin
    logic [7:0] txt [$];
    string      digits;
    int         i;
    int         j;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    random_alphabet();
    digits = "0123456789";
    for (i = 0; i < digits.len(); i++) alpha[i] = digits[i];
    cur_radix = 10;
    load_alphabet();
    txt = '{npcb_pkg::CharTab, npcb_pkg::CharNl, npcb_pkg::CharVt, npcb_pkg::CharFf,
            npcb_pkg::CharCr, npcb_pkg::CharSpace, npcb_pkg::CharMinus, npcb_pkg::CharPlus,
            "9"};
    send_bytes(txt);
    send_text("4294967296");
    txt = '{8'hFF};
    send_bytes(txt);
    txt = '{"1", npcb_pkg::CharNul, "5"};
    send_bytes(txt);
    txt = '{npcb_pkg::CharNul};
    send_bytes(txt);
    run_phase(1'b0);

    for (int p = 1; p < 15; p++) begin
      random_alphabet();
      cur_radix = $urandom_range(32, 2);
      case (p)
        1: begin
          digits = "0123456789ABCDEF";
          for (i = 0; i < digits.len(); i++) alpha[i] = digits[i];
          cur_radix = 16;
        end
        2: begin
          alpha[0] = "0";
          alpha[1] = "1";
          cur_radix = 2;
        end
        3: cur_radix = 32;
        4: cur_radix = 0;
        5: cur_radix = 1;
        6: cur_radix = 63;
        7: begin
          i = $urandom_range(cur_radix - 2);
          j = $urandom_range(cur_radix - 1, i + 1);
          alpha[j] = alpha[i];
        end
        8: alpha[$urandom_range(cur_radix - 1)] = illegal[$urandom_range(8)];
        13: cur_radix = 33;
        default: ;
      endcase
      load_alphabet();
      steady = (p == 3);
      if (p == 10) hold_req = 1'b1;
      run_phase(p == 1);
      steady = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d characters under %0d alphabet settings, %0d strings parsed.",
             items_sent, phases, board.results_seen);
    $display("Of those, %0d overflowed and %0d came from an invalid alphabet.",
             board.overflow_count, board.invalid_count);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
